// ----- src/box_downsample_contrast_remap_macros.svh -----
// assertion macros for the box downsample contrast remap block
// used by the top level; expects clk_i and rst_ni in scope
`ifndef BOX_DOWNSAMPLE_CONTRAST_REMAP_MACROS_SVH
`define BOX_DOWNSAMPLE_CONTRAST_REMAP_MACROS_SVH

// same-cycle implication
`define BDCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bdcr_pkg.sv -----
// shared types, register codes and the level remap function
// no dependencies
package bdcr_pkg;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned SUM_W = 12;
  localparam int unsigned LW_W  = 13;

  localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 13'd4096;
  localparam logic [CH_W-1:0] MIN_LEVEL_RESET  = 8'd0;
  localparam logic [CH_W-1:0] MAX_LEVEL_RESET  = 8'd255;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_MIN_LEVEL  = 2'd1,
    REG_MAX_LEVEL  = 2'd2
  } bdcr_reg_e;

  // per-pixel position flags from the position tracker
  typedef struct packed {
    logic in_range;
    logic restart;
    logic emit;
    logic row_end;
  } bdcr_pix_info_t;

  // stage status seen by the top level
  typedef struct packed {
    logic valid;
    logic emit;
  } bdcr_stage_status_t;

  // mean * (max - min) / 256 + min, division truncating toward zero
  function automatic logic [CH_W-1:0] remap_level(input logic [CH_W-1:0] mean,
                                                  input logic [CH_W-1:0] min_lvl,
                                                  input logic [CH_W-1:0] max_lvl);
    logic signed [9:0]  span;
    logic signed [17:0] prod;
    logic signed [17:0] adj;
    logic signed [17:0] quo;
    span = $signed({2'b00, max_lvl}) - $signed({2'b00, min_lvl});
    prod = 18'($signed({1'b0, mean})) * 18'(span);
    adj  = prod[17] ? (prod + 18'sd255) : prod;
    quo  = adj >>> 8;
    return min_lvl + quo[CH_W-1:0];
  endfunction

endpackage

// ----- src/box_downsample_contrast_remap.sv -----
// top level of the 4x4 box downsampler with contrast remap
// depends on bdcr_pkg, bdcr_cfg, bdcr_pos, bdcr_accum and the macros header
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------------------------------
//  pixel in | in_valid_i / in_stall_o       | red_in_i green_in_i blue_in_i frame_start_i
//  block out| out_valid_o / out_stall_i     | red_out_o green_out_o blue_out_o
//           |                               | out_column_o row_end_o
//  config   | psel penable pwrite / pready  | paddr pwdata prdata
//
// one pixel per clock unless stalled; block results pass stage then output register
// the accumulate stage read-modify-writes the column sum memory for each in-range pixel,
// with the previous write forwarded past the registered read
// reset clears counters and valid flags; the sum memory needs no clearing pass
// input stalls only while a finished block waits in the stage behind a stalled output
module box_downsample_contrast_remap #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bdcr_pkg::CH_W-1:0] red_in_i,
  input  logic [bdcr_pkg::CH_W-1:0] green_in_i,
  input  logic [bdcr_pkg::CH_W-1:0] blue_in_i,
  input  logic                      frame_start_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bdcr_pkg::CH_W-1:0] red_out_o,
  output logic [bdcr_pkg::CH_W-1:0] green_out_o,
  output logic [bdcr_pkg::CH_W-1:0] blue_out_o,
  output logic [9:0]                out_column_o,
  output logic                      row_end_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import bdcr_pkg::*;

  `include "box_downsample_contrast_remap_macros.svh"

  localparam int unsigned AW = $clog2(MAX_WIDTH / 4);

  logic [LW_W-1:0]    line_width;
  logic [CH_W-1:0]    min_level;
  logic [CH_W-1:0]    max_level;
  logic [AW-1:0]      block_idx;
  bdcr_pix_info_t     pix_info;
  bdcr_stage_status_t stg_status;
  logic               accept;
  logic               stg_done;
  logic               out_blocked;

  assign accept      = in_valid_i && !in_stall_o;
  assign stg_done    = stg_status.valid && stg_status.emit;
  assign out_blocked = out_valid_o && out_stall_i;

  bdcr_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .line_width_o (line_width),
    .min_level_o  (min_level),
    .max_level_o  (max_level)
  );

  bdcr_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_start_i (frame_start_i),
    .line_width_i  (line_width),
    .block_idx_o   (block_idx),
    .info_o        (pix_info)
  );

  bdcr_accum #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_in_i),
    .green_i     (green_in_i),
    .blue_i      (blue_in_i),
    .block_idx_i (block_idx),
    .info_i      (pix_info),
    .min_level_i (min_level),
    .max_level_i (max_level),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_out_o),
    .green_o     (green_out_o),
    .blue_o      (blue_out_o),
    .column_o    (out_column_o),
    .row_end_o   (row_end_o),
    .status_o    (stg_status)
  );

  // input only waits on a finished block stuck behind a stalled output
  `BDCR_ASSERT_IMPL(a_stall_cause, in_stall_o, stg_done && out_blocked, "stray input stall")
  // a new result comes only from an emitting stage item
  `BDCR_ASSERT_NEXT(a_out_source, !out_valid_o && !stg_done, !out_valid_o, "stray result")

endmodule

// ----- src/bdcr_cfg.sv -----
// apb register file: line width, min and max level
// depends on bdcr_pkg
module bdcr_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic [bdcr_pkg::LW_W-1:0] line_width_o,
  output logic [bdcr_pkg::CH_W-1:0] min_level_o,
  output logic [bdcr_pkg::CH_W-1:0] max_level_o
);
  import bdcr_pkg::*;

  logic [LW_W-1:0] line_width_q;
  logic [CH_W-1:0] min_level_q;
  logic [CH_W-1:0] max_level_q;
  logic            wr_en;
  bdcr_reg_e       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = bdcr_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RESET;
      min_level_q  <= MIN_LEVEL_RESET;
      max_level_q  <= MAX_LEVEL_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_LINE_WIDTH: line_width_q <= pwdata[LW_W-1:0];
        REG_MIN_LEVEL:  min_level_q  <= pwdata[CH_W-1:0];
        REG_MAX_LEVEL:  max_level_q  <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LINE_WIDTH: prdata = 32'(line_width_q);
      REG_MIN_LEVEL:  prdata = 32'(min_level_q);
      REG_MAX_LEVEL:  prdata = 32'(max_level_q);
      default:        prdata = 32'd0;
    endcase
  end

  assign line_width_o = line_width_q;
  assign min_level_o  = min_level_q;
  assign max_level_o  = max_level_q;

endmodule

// ----- src/bdcr_pos.sv -----
// source position tracker: column and row phase counters, block flags
// depends on bdcr_pkg
module bdcr_pos #(
  parameter int unsigned MAX_WIDTH = 4096,
  localparam int unsigned AW = $clog2(MAX_WIDTH / 4)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       frame_start_i,
  input  logic [bdcr_pkg::LW_W-1:0]  line_width_i,
  output logic [AW-1:0]              block_idx_o,
  output bdcr_pkg::bdcr_pix_info_t   info_o
);
  import bdcr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned EW = (WW > LW_W) ? WW : LW_W;

  logic [CW-1:0] col_q, col_d, col_cur;
  logic [1:0]    phase_q, phase_d, phase_cur;
  logic [EW-1:0] lw_ext;
  logic [EW-1:0] w_ext;
  logic [WW-1:0] w;
  logic [WW-1:0] blk4;
  logic [WW-1:0] col_nxt;
  logic [WW-3:0] last_blk;
  logic [WW-3:0] cur_blk;

  // clamp the width to 4..MAX_WIDTH
  always_comb begin
    lw_ext = EW'(line_width_i);
    if (lw_ext < EW'(4)) begin
      w_ext = EW'(4);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      w_ext = EW'(MAX_WIDTH);
    end else begin
      w_ext = lw_ext;
    end
    w        = w_ext[WW-1:0];
    blk4     = {w[WW-1:2], 2'b00};
    last_blk = w[WW-1:2] - (WW-2)'(1);
  end

  always_comb begin
    col_cur   = frame_start_i ? '0 : col_q;
    phase_cur = frame_start_i ? '0 : phase_q;
    cur_blk   = (WW-2)'(col_cur[CW-1:2]);
    info_o.in_range = WW'(col_cur) < blk4;
    info_o.restart  = (phase_cur == 2'd0) && (col_cur[1:0] == 2'd0);
    info_o.emit     = (phase_cur == 2'd3) && (col_cur[1:0] == 2'd3);
    info_o.row_end  = cur_blk == last_blk;
    block_idx_o     = col_cur[AW+1:2];
    col_nxt = WW'(col_cur) + WW'(1);
    if (col_nxt >= w) begin
      col_d   = '0;
      phase_d = phase_cur + 2'd1;
    end else begin
      col_d   = col_nxt[CW-1:0];
      phase_d = phase_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      phase_q <= '0;
    end else if (accept_i) begin
      col_q   <= col_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ----- src/bdcr_accum.sv -----
// column sum memory, accumulate stage with write forwarding, remap and output register
// depends on bdcr_pkg
module bdcr_accum #(
  parameter int unsigned MAX_WIDTH = 4096,
  localparam int unsigned AW = $clog2(MAX_WIDTH / 4)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bdcr_pkg::CH_W-1:0]     red_i,
  input  logic [bdcr_pkg::CH_W-1:0]     green_i,
  input  logic [bdcr_pkg::CH_W-1:0]     blue_i,
  input  logic [AW-1:0]                 block_idx_i,
  input  bdcr_pkg::bdcr_pix_info_t      info_i,
  input  logic [bdcr_pkg::CH_W-1:0]     min_level_i,
  input  logic [bdcr_pkg::CH_W-1:0]     max_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bdcr_pkg::CH_W-1:0]     red_o,
  output logic [bdcr_pkg::CH_W-1:0]     green_o,
  output logic [bdcr_pkg::CH_W-1:0]     blue_o,
  output logic [9:0]                    column_o,
  output logic                          row_end_o,
  output bdcr_pkg::bdcr_stage_status_t  status_o
);
  import bdcr_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH / 4;

  logic [2:0][SUM_W-1:0] mem [DEPTH];

  logic                  stg_valid_q;
  logic [2:0][CH_W-1:0]  stg_px_q;
  logic [AW-1:0]         stg_idx_q;
  bdcr_pix_info_t        stg_info_q;
  logic [2:0][SUM_W-1:0] rd_q;
  logic                  fwd_en_q;
  logic [AW-1:0]         fwd_idx_q;
  logic [2:0][SUM_W-1:0] fwd_val_q;

  logic                  out_valid_q;
  logic [2:0][CH_W-1:0]  out_px_q;
  logic [9:0]            out_col_q;
  logic                  out_row_end_q;

  logic                  accept;
  logic                  stg_emit;
  logic                  stg_adv;
  logic                  stg_wr;
  logic [2:0][SUM_W-1:0] base;
  logic [2:0][SUM_W-1:0] sum;
  logic [2:0][CH_W-1:0]  level;
  logic [AW+9:0]         idx_ext;

  assign stg_emit   = stg_valid_q && stg_info_q.in_range && stg_info_q.emit;
  // stage moves on unless it holds a result and the output is blocked
  assign stg_adv    = !stg_emit || !out_valid_q || !out_stall_i;
  assign in_stall_o = stg_valid_q && !stg_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign stg_wr     = stg_valid_q && stg_adv && stg_info_q.in_range;

  always_comb begin
    // the item that left the stage at our read edge wrote after the read
    base = (fwd_en_q && (fwd_idx_q == stg_idx_q)) ? fwd_val_q : rd_q;
    for (int ch = 0; ch < 3; ch++) begin
      if (stg_info_q.restart) begin
        sum[ch] = SUM_W'(stg_px_q[ch]);
      end else begin
        sum[ch] = base[ch] + SUM_W'(stg_px_q[ch]);
      end
      level[ch] = remap_level(sum[ch][SUM_W-1:SUM_W-CH_W], min_level_i, max_level_i);
    end
    idx_ext = (AW + 10)'(stg_idx_q);
  end

  always_ff @(posedge clk_i) begin
    if (stg_wr) begin
      mem[stg_idx_q] <= sum;
    end
    if (accept) begin
      rd_q      <= mem[block_idx_i];
      fwd_idx_q <= stg_idx_q;
      fwd_val_q <= sum;
      stg_px_q  <= {blue_i, green_i, red_i};
      stg_idx_q <= block_idx_i;
      stg_info_q <= info_i;
    end
    if (stg_valid_q && stg_adv && stg_emit) begin
      out_px_q      <= level;
      out_col_q     <= idx_ext[9:0];
      out_row_end_q <= stg_info_q.row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      fwd_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fwd_en_q <= stg_wr;
      end
      if (stg_adv) begin
        stg_valid_q <= accept;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (stg_valid_q && stg_adv && stg_emit) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_o           = out_px_q[0];
  assign green_o         = out_px_q[1];
  assign blue_o          = out_px_q[2];
  assign column_o        = out_col_q;
  assign row_end_o       = out_row_end_q;
  assign status_o.valid  = stg_valid_q;
  assign status_o.emit   = stg_emit;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for box_downsample_contrast_remap: 4x4 block means with level remap
// needs bdcr_pkg and the block's rtl; a scoreboard class predicts every reduced pixel
module testbench;
  import bdcr_pkg::*;

  localparam int unsigned MAX_W         = 4096;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_start;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [9:0]      column;
    logic            row_end;
  } block_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {FILL_WHITE, FILL_BLACK, FILL_RANDOM, FILL_EXTREME} fill_e;

  class box_mean_predictor;
    logic [LW_W-1:0]  line_width = LINE_WIDTH_RESET;
    logic [CH_W-1:0]  min_level  = MIN_LEVEL_RESET;
    logic [CH_W-1:0]  max_level  = MAX_LEVEL_RESET;
    logic [SUM_W-1:0] sums [3][MAX_W/4];
    int unsigned      column;
    int unsigned      row_phase;
    block_t           pending_blocks[$];
    int unsigned      errors;
    int unsigned      pixels_seen;
    int unsigned      blocks_seen;

    task flag_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void set_register(bdcr_reg_e idx, logic [31:0] value);
      case (idx)
        REG_LINE_WIDTH: line_width = value[LW_W-1:0];
        REG_MIN_LEVEL:  min_level  = value[CH_W-1:0];
        REG_MAX_LEVEL:  max_level  = value[CH_W-1:0];
        default: ;
      endcase
    endfunction

    // int division truncates toward zero, which is what an inverted range needs
    function logic [CH_W-1:0] remap(logic [SUM_W-1:0] sum);
      int mean;
      int hi;
      int lo;
      mean = int'(sum[SUM_W-1:4]);
      hi   = int'(max_level);
      lo   = int'(min_level);
      return CH_W'(lo + (mean * (hi - lo)) / 256);
    endfunction

    function void take_pixel(pixel_t p);
      logic [CH_W-1:0] px [3];
      int unsigned     w;
      int unsigned     blocks;
      int unsigned     idx;
      int unsigned     sub;
      int              ch;
      block_t          blk;
      px[0] = p.red;
      px[1] = p.green;
      px[2] = p.blue;
      pixels_seen++;
      if (p.frame_start) begin
        column    = 0;
        row_phase = 0;
      end
      w = 32'(line_width);
      if (w < 4) begin
        w = 4;
      end else if (w > MAX_W) begin
        w = MAX_W;
      end
      blocks = w / 4;
      if (column < blocks * 4) begin
        idx = column / 4;
        sub = column % 4;
        for (ch = 0; ch < 3; ch++) begin
          if (row_phase == 0 && sub == 0) begin
            sums[ch][idx] = SUM_W'(px[ch]);
          end else begin
            sums[ch][idx] = sums[ch][idx] + SUM_W'(px[ch]);
          end
        end
        if (row_phase == 3 && sub == 3) begin
          blk.red     = remap(sums[0][idx]);
          blk.green   = remap(sums[1][idx]);
          blk.blue    = remap(sums[2][idx]);
          blk.column  = 10'(idx);
          blk.row_end = (idx == blocks - 1);
          pending_blocks.push_back(blk);
        end
      end
      column++;
      if (column >= w) begin
        column    = 0;
        row_phase = (row_phase + 1) % 4;
      end
    endfunction

    task check_block(block_t got);
      block_t want;
      if (pending_blocks.size() == 0) begin
        flag_mismatch($sformatf("block at column %0d with nothing expected", got.column));
      end else begin
        want = pending_blocks.pop_front();
        blocks_seen++;
        if (got.red !== want.red)
          flag_mismatch($sformatf("column %0d red: got %0d, want %0d",
                                  want.column, got.red, want.red));
        if (got.green !== want.green)
          flag_mismatch($sformatf("column %0d green: got %0d, want %0d",
                                  want.column, got.green, want.green));
        if (got.blue !== want.blue)
          flag_mismatch($sformatf("column %0d blue: got %0d, want %0d",
                                  want.column, got.blue, want.blue));
        if (got.column !== want.column)
          flag_mismatch($sformatf("column index: got %0d, want %0d", got.column, want.column));
        if (got.row_end !== want.row_end)
          flag_mismatch($sformatf("column %0d row end: got %0b, want %0b",
                                  want.column, got.row_end, want.row_end));
      end
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [CH_W-1:0]     red_in_i      = '0;
  logic [CH_W-1:0]     green_in_i    = '0;
  logic [CH_W-1:0]     blue_in_i     = '0;
  logic                frame_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [CH_W-1:0]     red_out_o;
  logic [CH_W-1:0]     green_out_o;
  logic [CH_W-1:0]     blue_out_o;
  logic [9:0]          out_column_o;
  logic                row_end_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [3:0]          paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;

  idle_mode_e          idle_mode     = IDLE_NONE;
  int unsigned         settings_used = 0;
  box_mean_predictor   predictor;

  box_downsample_contrast_remap #(
    .MAX_WIDTH(MAX_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .out_column_o (out_column_o),
    .row_end_o    (row_end_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // both channels sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      predictor.take_pixel(pixel_t'{red_in_i, green_in_i, blue_in_i, frame_start_i});
    if (rst_ni && out_valid_o && !out_stall_i)
      predictor.check_block(block_t'{red_out_o, green_out_o, blue_out_o,
                                     out_column_o, row_end_o});
  end

  always @(negedge clk_i) begin
    case (idle_mode)
      IDLE_RECEIVER: out_stall_i <= ($urandom_range(99) < 74);
      IDLE_BOTH:     out_stall_i <= ($urandom_range(99) < 27);
      default:       out_stall_i <= 1'b0;
    endcase
  end

  function automatic bit sender_pauses();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 74;
      IDLE_BOTH:   return $urandom_range(99) < 27;
      default:     return 1'b0;
    endcase
  endfunction

  task automatic send_pixel(pixel_t p);
    @(negedge clk_i);
    while (sender_pauses()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    red_in_i      <= p.red;
    green_in_i    <= p.green;
    blue_in_i     <= p.blue;
    frame_start_i <= p.frame_start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (predictor.pending_blocks.size() != 0) @(posedge clk_i);
    // a trailing pixel with no result may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write transaction followed by a read-back transaction of the same register
  task automatic write_register(bdcr_reg_e idx, logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] mask;
    mask = (idx == REG_LINE_WIDTH) ? 32'h1fff : 32'h00ff;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    predictor.set_register(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((readback & mask) !== (value & mask))
      predictor.flag_mismatch($sformatf("register %s reads %0d, wrote %0d",
                                        idx.name(), readback & mask, value & mask));
  endtask

  task automatic apply_setting(int unsigned width, int unsigned lo, int unsigned hi);
    write_register(REG_LINE_WIDTH, width);
    write_register(REG_MIN_LEVEL, lo);
    write_register(REG_MAX_LEVEL, hi);
    settings_used++;
  endtask

  // restart_pm: chance per thousand of a stray frame start inside the stream
  task automatic run_stream(idle_mode_e mode, int unsigned count, fill_e fill,
                            bit restart, int unsigned restart_pm);
    pixel_t p;
    idle_mode = mode;
    for (int unsigned i = 0; i < count; i++) begin
      case (fill)
        FILL_WHITE: p = '{8'hff, 8'hff, 8'hff, 1'b0};
        FILL_BLACK: p = '{8'h00, 8'h00, 8'h00, 1'b0};
        FILL_EXTREME: begin
          p.red   = {8{$urandom_range(1) == 1}};
          p.green = {8{$urandom_range(1) == 1}};
          p.blue  = {8{$urandom_range(1) == 1}};
        end
        default: begin
          p.red   = 8'($urandom_range(255));
          p.green = 8'($urandom_range(255));
          p.blue  = 8'($urandom_range(255));
        end
      endcase
      p.frame_start = (i == 0) ? restart : ($urandom_range(999) < restart_pm);
      send_pixel(p);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  function automatic int unsigned pick_level();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 30) return 255;
    return $urandom_range(255);
  endfunction

  initial begin
    int unsigned random_items;
    int unsigned phase_no;
    int unsigned width;
    int unsigned w_eff;
    int unsigned count;
    int unsigned r;
    fill_e       fill;

    predictor = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset width: part of a row, no group completes
    run_stream(IDLE_NONE, 64, FILL_RANDOM, 1'b1, 0);

    // reset levels at a narrow width
    write_register(REG_LINE_WIDTH, 8);
    run_stream(IDLE_NONE, 64, FILL_RANDOM, 1'b1, 0);

    // narrowest block, full-scale white then black; width below 4 clamps up
    apply_setting(3, 0, 255);
    run_stream(IDLE_NONE, 16, FILL_WHITE, 1'b1, 0);
    run_stream(IDLE_SENDER, 16, FILL_BLACK, 1'b0, 0);

    // inverted range falls from min toward max
    apply_setting(0, 255, 0);
    run_stream(IDLE_RECEIVER, 16, FILL_EXTREME, 1'b1, 0);

    // flat range; the fifth column sits outside every block
    apply_setting(5, 128, 128);
    run_stream(IDLE_BOTH, 20, FILL_RANDOM, 1'b1, 0);

    // width shrunk in mid-line: the position is already past the new width
    apply_setting(12, 0, 255);
    run_stream(IDLE_NONE, 6, FILL_RANDOM, 1'b1, 0);
    write_register(REG_LINE_WIDTH, 4);
    predictor.set_register(REG_LINE_WIDTH, 4);
    run_stream(IDLE_SENDER, 13, FILL_RANDOM, 1'b0, 0);

    // width past the maximum clamps down
    apply_setting(8191, 10, 245);
    run_stream(IDLE_BOTH, 64, FILL_RANDOM, 1'b1, 0);

    random_items = 0;
    phase_no     = 0;
    while (random_items < 1000) begin
      r = $urandom_range(99);
      if (r < 6) begin
        width = $urandom_range(3);
      end else if (r < 90) begin
        width = $urandom_range(24, 4);
      end else begin
        width = $urandom_range(160, 25);
      end
      w_eff = (width < 4) ? 4 : width;
      apply_setting(width, pick_level(), pick_level());
      // whole groups plus a ragged tail that never completes a group
      count = $urandom_range((w_eff > 24) ? 1 : 3, 1) * 4 * w_eff
              + $urandom_range(2 * w_eff);
      fill = ($urandom_range(3) == 0) ? FILL_EXTREME : FILL_RANDOM;
      run_stream(idle_mode_e'(phase_no % 4), count, fill, 1'b1, 8);
      random_items += count;
      phase_no++;
    end

    idle_mode = IDLE_NONE;
    wait_drained();
    if (predictor.pending_blocks.size() != 0)
      predictor.flag_mismatch($sformatf("%0d expected blocks never arrived",
                                        predictor.pending_blocks.size()));
    $display("run covered %0d pixels and %0d reduced blocks over %0d register settings",
             predictor.pixels_seen, predictor.blocks_seen, settings_used);
    $display("widths from 0 to 8191, level ranges flat, full and inverted, all idle modes");
    if (predictor.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d blocks still expected", predictor.pending_blocks.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
